// ===== sv/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rrsch_pkg.sv =====
// Types and constants for the round-robin / fixed-priority task scheduler.
// No dependencies.
package rrsch_pkg;

    localparam int NUM_DEVICES_DEF = 4;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int PRESS_W    = 4;
    localparam int SVC_REGS   = 4;
    localparam int SVC_W      = 16;
    localparam int RESP_W     = 32;
    localparam int DEV_OUT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_C  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SVC_D  = 3'd4;

    typedef enum logic [2:0] {
        ST_BLOCKED = 3'b001,
        ST_READY   = 3'b010,
        ST_RUNNING = 3'b100
    } t_dev_state;

    typedef logic [PRESS_W-1:0] t_press;

    typedef struct packed {
        logic                  done_valid;
        logic [DEV_OUT_W-1:0]  done_device;
        logic [RESP_W-1:0]     response_time;
        logic                  start_valid;
        logic [DEV_OUT_W-1:0]  start_device;
        logic                  all_blocked_event;
        logic [PRESS_W-1:0]    ignored_mask;
    } t_result;

endpackage

// ===== sv/rrsch_tick_if.sv =====
// Tick channel: valid/ready with the press mask payload.
// Depends on rrsch_pkg.
interface rrsch_tick_if
    import rrsch_pkg::*;
;
    logic   valid;
    logic   ready;
    t_press press_mask;

    modport source (output valid, output press_mask, input ready);
    modport sink   (input valid, input press_mask, output ready);
endinterface

// ===== sv/rrsch_res_if.sv =====
// Result channel: valid/ready with one scheduler result per tick.
// Depends on rrsch_pkg.
interface rrsch_res_if
    import rrsch_pkg::*;
;
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/four_task_rr_priority_scheduler_top.sv =====
// Scheduler top level: tick input register, single-pass scheduling logic, result register.
// Depends on rrsch_pkg, rrsch_tick_if, rrsch_res_if and assert_macros.svh.
//
// One tick transfer is taken per clock cycle unless a held tick waits on a stalled result
// side; each yields exactly one result transfer through both registers. Press intake, the
// finish test (elapsed time against the service time, a TIME_WIDTH subtract and
// compare) and the round-robin or lowest-index start selection all sit in one
// combinational pass between the tick register and the result register; that pass sets
// the clock rate. Either register may hold a transfer while the other side stalls, so a
// new tick is accepted while a finished result waits. Configuration writes take effect
// at the next edge and are meant for idle periods only.
`include "assert_macros.svh"

module four_task_rr_priority_scheduler_top
    import rrsch_pkg::*;
#(
    parameter int NUM_DEVICES = NUM_DEVICES_DEF,
    parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    rrsch_tick_if.sink            i_tick,
    rrsch_res_if.source           o_res
);

    localparam int IDX_W = $clog2(NUM_DEVICES);
    localparam logic [IDX_W:0] N_EXT = (IDX_W + 1)'(NUM_DEVICES);

    // Control state
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic                  r_mode;
    logic [SVC_W-1:0]      r_svc [SVC_REGS];
    t_dev_state            r_status [NUM_DEVICES];
    logic [TIME_WIDTH-1:0] r_tick;
    logic [IDX_W-1:0]      r_ptr;
    logic                  r_rr_flag;
    logic                  r_fq_flag;

    // Payload
    t_press                r_press;
    t_result               r_res;
    logic [TIME_WIDTH-1:0] r_ready_stamp [NUM_DEVICES];
    logic [TIME_WIDTH-1:0] r_start_stamp [NUM_DEVICES];

    t_dev_state            n_status [NUM_DEVICES];
    logic [TIME_WIDTH-1:0] n_ready_stamp [NUM_DEVICES];
    logic [TIME_WIDTH-1:0] n_start_stamp [NUM_DEVICES];
    logic [IDX_W-1:0]      n_ptr;
    logic                  n_rr_flag;
    logic                  n_fq_flag;
    t_result               n_res;

    logic                  adv;
    logic                  in_xfer;
    logic [SVC_W-1:0]      svc_v   [NUM_DEVICES];
    logic [TIME_WIDTH-1:0] elapsed [NUM_DEVICES];
    logic [TIME_WIDTH-1:0] resp_v  [NUM_DEVICES];
    logic [NUM_DEVICES-1:0] running_vec;

    assign adv         = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_in_valid || adv;
    assign in_xfer     = i_tick.valid && i_tick.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    always_comb begin
        for (int i = 0; i < NUM_DEVICES; i++) begin
            svc_v[i]       = (i < SVC_REGS) ? r_svc[2'(i)] : '0;
            elapsed[i]     = r_tick - r_start_stamp[i];
            resp_v[i]      = r_tick - r_ready_stamp[i];
            running_vec[i] = (r_status[i] == ST_RUNNING);
        end
    end

    always_comb begin
        logic [NUM_DEVICES-1:0] press;
        logic [NUM_DEVICES-1:0] ign;
        logic                   still_run;
        logic                   done_v;
        logic [IDX_W-1:0]       done_idx;
        logic [TIME_WIDTH-1:0]  resp;
        logic                   start_v;
        logic [IDX_W-1:0]       start_idx;
        logic [IDX_W:0]         sum;
        logic [IDX_W-1:0]       cand;
        logic                   all_blk;
        logic                   flag;
        logic                   evt;

        n_status      = r_status;
        n_ready_stamp = r_ready_stamp;
        n_start_stamp = r_start_stamp;
        n_ptr         = r_ptr;
        n_rr_flag     = r_rr_flag;
        n_fq_flag     = r_fq_flag;
        press         = NUM_DEVICES'(r_press);
        ign           = '0;
        still_run     = 1'b0;
        done_v        = 1'b0;
        done_idx      = '0;
        resp          = '0;
        start_v       = 1'b0;
        start_idx     = '0;
        sum           = '0;
        cand          = '0;
        all_blk       = 1'b1;
        evt           = 1'b0;

        // presses
        for (int i = 0; i < NUM_DEVICES; i++) begin
            if (press[i]) begin
                if (r_status[i] == ST_BLOCKED && svc_v[i] != '0) begin
                    n_status[i]      = ST_READY;
                    n_ready_stamp[i] = r_tick;
                end else if (svc_v[i] == '0) begin
                    ign[i] = 1'b1;
                end
            end
        end

        // finish
        for (int i = 0; i < NUM_DEVICES; i++) begin
            if (r_status[i] == ST_RUNNING) begin
                if (elapsed[i] >= TIME_WIDTH'(svc_v[i])) begin
                    done_v      = 1'b1;
                    done_idx    = IDX_W'(i);
                    resp        = resp_v[i];
                    n_status[i] = ST_BLOCKED;
                end else begin
                    still_run = 1'b1;
                end
            end
        end

        // start
        if (!still_run) begin
            for (int k = 0; k < NUM_DEVICES; k++) begin
                sum = r_mode ? ({1'b0, r_ptr} + (IDX_W + 1)'(k)) : (IDX_W + 1)'(k);
                if (sum >= N_EXT) begin
                    sum = sum - N_EXT;
                end
                cand = sum[IDX_W-1:0];
                if (!start_v && n_status[cand] == ST_READY) begin
                    start_v   = 1'b1;
                    start_idx = cand;
                end
            end
            if (start_v) begin
                n_status[start_idx]      = ST_RUNNING;
                n_start_stamp[start_idx] = r_tick;
                if (r_mode) begin
                    sum   = {1'b0, start_idx} + (IDX_W + 1)'(1);
                    n_ptr = (sum >= N_EXT) ? '0 : sum[IDX_W-1:0];
                end
            end
        end

        // all-blocked notice, per-mode flag
        for (int i = 0; i < NUM_DEVICES; i++) begin
            if (n_status[i] != ST_BLOCKED) begin
                all_blk = 1'b0;
            end
        end
        flag = r_mode ? r_rr_flag : r_fq_flag;
        if (start_v) begin
            flag = 1'b0;
        end else begin
            evt  = all_blk && !flag;
            flag = all_blk;
        end
        if (r_mode) begin
            n_rr_flag = flag;
        end else begin
            n_fq_flag = flag;
        end

        n_res.done_valid        = done_v;
        n_res.done_device       = DEV_OUT_W'(done_idx);
        n_res.response_time     = RESP_W'(resp);
        n_res.start_valid       = start_v;
        n_res.start_device      = DEV_OUT_W'(start_idx);
        n_res.all_blocked_event = evt;
        n_res.ignored_mask      = PRESS_W'(ign);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b1;
            r_tick      <= '0;
            r_ptr       <= '0;
            r_rr_flag   <= 1'b0;
            r_fq_flag   <= 1'b0;
            for (int i = 0; i < SVC_REGS; i++) begin
                r_svc[i] <= '0;
            end
            for (int i = 0; i < NUM_DEVICES; i++) begin
                r_status[i] <= ST_BLOCKED;
            end
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (adv) begin
                r_status  <= n_status;
                r_tick    <= r_tick + TIME_WIDTH'(1);
                r_ptr     <= n_ptr;
                r_rr_flag <= n_rr_flag;
                r_fq_flag <= n_fq_flag;
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MODE:  r_mode   <= i_cfg_wdata[0];
                    REG_SVC_A: r_svc[0] <= i_cfg_wdata;
                    REG_SVC_B: r_svc[1] <= i_cfg_wdata;
                    REG_SVC_C: r_svc[2] <= i_cfg_wdata;
                    REG_SVC_D: r_svc[3] <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_press <= i_tick.press_mask;
        end
        if (adv) begin
            r_res         <= n_res;
            r_ready_stamp <= n_ready_stamp;
            r_start_stamp <= n_start_stamp;
        end
    end

    `ASSERT_SAME(a_one_running, i_clk, i_rst_n, 1'b1,
                 $onehot0(running_vec), "more than one device running")
    `ASSERT_NEXT(a_tick_hold, i_clk, i_rst_n, r_in_valid && !adv,
                 r_in_valid && $stable(r_press), "held tick lost")
    `ASSERT_SAME(a_evt_no_start, i_clk, i_rst_n, r_out_valid && r_res.all_blocked_event,
                 !r_res.start_valid, "notice with a start")

endmodule

// ===== tb/rrsch_sched_checker.sv =====
// Result checker for the scheduler: tracks tick and result transfers, predicts each result.
// Depends on rrsch_pkg; fed with the channel and configuration signals from the bench top.
module rrsch_sched_checker
    import rrsch_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_tick_valid,
    input  logic                  i_tick_ready,
    input  t_press                i_press_mask,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  t_result               i_res_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int NDEV = NUM_DEVICES_DEF;

    t_dev_state       dev_state  [NDEV];
    logic [31:0]      ready_at   [NDEV];
    logic [31:0]      started_at [NDEV];
    logic [SVC_W-1:0] svc_ticks  [NDEV];
    logic [31:0]      now_tick;
    logic [1:0]       rr_ptr;
    logic             rr_mode;
    logic             rr_blocked_seen;
    logic             fp_blocked_seen;
    t_result          sched_results [$];
    int               fail_count = 0;
    int               pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    // One tick: presses, then finish test, then start selection, then all-blocked notice
    function automatic t_result schedule_tick(t_press presses);
        t_result     r;
        logic        busy;
        logic        all_idle;
        logic [1:0]  idx;
        logic [31:0] elapsed;
        int          i;
        r    = '0;
        busy = 1'b0;
        for (i = 0; i < NDEV; i++) begin
            if (presses[i]) begin
                if (dev_state[i] == ST_BLOCKED && svc_ticks[i] != '0) begin
                    dev_state[i] = ST_READY;
                    ready_at[i]  = now_tick;
                end else if (svc_ticks[i] == '0) begin
                    r.ignored_mask[i] = 1'b1;
                end
            end
        end
        for (i = 0; i < NDEV; i++) begin
            if (dev_state[i] == ST_RUNNING) begin
                elapsed = now_tick - started_at[i];
                if (elapsed >= 32'(svc_ticks[i])) begin
                    r.done_valid    = 1'b1;
                    r.done_device   = 2'(i);
                    r.response_time = now_tick - ready_at[i];
                    dev_state[i]    = ST_BLOCKED;
                end else begin
                    busy = 1'b1;
                end
            end
        end
        if (!busy) begin
            for (i = 0; i < NDEV && !r.start_valid; i++) begin
                idx = rr_mode ? rr_ptr + 2'(i) : 2'(i);
                if (dev_state[idx] == ST_READY) begin
                    dev_state[idx]  = ST_RUNNING;
                    started_at[idx] = now_tick;
                    r.start_valid   = 1'b1;
                    r.start_device  = idx;
                    if (rr_mode) begin
                        rr_ptr = idx + 2'd1;
                    end
                end
            end
        end
        all_idle = 1'b1;
        for (i = 0; i < NDEV; i++) begin
            if (dev_state[i] != ST_BLOCKED) begin
                all_idle = 1'b0;
            end
        end
        // each mode keeps its own flag
        if (rr_mode) begin
            if (r.start_valid) begin
                rr_blocked_seen = 1'b0;
            end else begin
                r.all_blocked_event = all_idle && !rr_blocked_seen;
                rr_blocked_seen     = all_idle;
            end
        end else begin
            if (r.start_valid) begin
                fp_blocked_seen = 1'b0;
            end else begin
                r.all_blocked_event = all_idle && !fp_blocked_seen;
                fp_blocked_seen     = all_idle;
            end
        end
        now_tick = now_tick + 32'd1;
        return r;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        int      i;
        if (!i_rst_n) begin
            for (i = 0; i < NDEV; i++) begin
                dev_state[i]  = ST_BLOCKED;
                ready_at[i]   = '0;
                started_at[i] = '0;
                svc_ticks[i]  = '0;
            end
            now_tick        = '0;
            rr_ptr          = '0;
            rr_mode         = 1'b1;
            rr_blocked_seen = 1'b0;
            fp_blocked_seen = 1'b0;
            sched_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_MODE:  rr_mode      = i_cfg_wdata[0];
                    REG_SVC_A: svc_ticks[0] = i_cfg_wdata;
                    REG_SVC_B: svc_ticks[1] = i_cfg_wdata;
                    REG_SVC_C: svc_ticks[2] = i_cfg_wdata;
                    REG_SVC_D: svc_ticks[3] = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                sched_results.push_back(schedule_tick(i_press_mask));
            end
            if (i_res_valid && i_res_ready) begin
                if (sched_results.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    fail_count++;
                end else begin
                    want = sched_results.pop_front();
                    check_field("done_valid", 32'(want.done_valid),
                                32'(i_res_data.done_valid));
                    check_field("done_device", 32'(want.done_device),
                                32'(i_res_data.done_device));
                    check_field("response_time", want.response_time,
                                i_res_data.response_time);
                    check_field("start_valid", 32'(want.start_valid),
                                32'(i_res_data.start_valid));
                    check_field("start_device", 32'(want.start_device),
                                32'(i_res_data.start_device));
                    check_field("all_blocked_event", 32'(want.all_blocked_event),
                                32'(i_res_data.all_blocked_event));
                    check_field("ignored_mask", 32'(want.ignored_mask),
                                32'(i_res_data.ignored_mask));
                end
            end
        end
        pending_count = sched_results.size();
    end

endmodule

// ===== tb/tb_four_task_rr_priority_scheduler_top.sv =====
// Bench top for the scheduler: clock, reset, tick stimulus, result back-pressure, verdict.
// Depends on rrsch_pkg, rrsch_tick_if, rrsch_res_if, the scheduler top and rrsch_sched_checker.
module tb_four_task_rr_priority_scheduler_top;
    import rrsch_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 240;
    localparam int RAND_TICKS  = 830;
    localparam int TAIL_TICKS  = 120;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_count;
    int                    pending;
    int                    gap_pct = 0;
    int                    idle_cycles = 0;
    bit                    hold_req = 1'b0;
    bit                    hold_done = 1'b0;

    rrsch_tick_if tick_ch ();
    rrsch_res_if  res_ch ();

    always #4 clk = ~clk;

    four_task_rr_priority_scheduler_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_tick      (tick_ch),
        .o_res       (res_ch)
    );

    rrsch_sched_checker sched_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_tick_valid (tick_ch.valid),
        .i_tick_ready (tick_ch.ready),
        .i_press_mask (tick_ch.press_mask),
        .i_res_valid  (res_ch.valid),
        .i_res_ready  (res_ch.ready),
        .i_res_data   (res_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // entered and left at a falling edge
    task automatic send_tick(input t_press presses);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            tick_ch.valid      = 1'b0;
            tick_ch.press_mask = 4'($urandom);
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        tick_ch.valid      = 1'b1;
        tick_ch.press_mask = presses;
        do @(posedge clk); while (!tick_ch.ready);
        @(negedge clk);
    endtask

    task automatic settle();
        tick_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    function automatic logic [SVC_W-1:0] pick_service();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            3, 4:    return 16'($urandom_range(9, 40));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic t_press pick_presses();
        case ($urandom_range(0, 9))
            5, 6, 7: return t_press'(1 << $urandom_range(0, 3));
            8:       return 4'($urandom);
            9:       return 4'hF;
            default: return '0;
        endcase
    endfunction

    // result side back-pressure, including one long hold-off
    initial begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                res_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done    = 1'b1;
                res_ch.ready = 1'b1;
            end else if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge clk);
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int sent;
        int len;
        int k;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_MODE;
        cfg_wdata          = '0;
        tick_ch.valid      = 1'b0;
        tick_ch.press_mask = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: every press ignored, first tick gives the notice
        send_tick(4'h0);
        send_tick(4'hF);
        send_tick(4'hA);

        settle();
        write_reg(REG_MODE, 16'h0001);
        write_reg(REG_SVC_A, 16'd1);
        write_reg(REG_SVC_B, 16'd2);
        write_reg(REG_SVC_C, 16'd3);
        write_reg(REG_SVC_D, 16'hFFFF);
        write_reg(3'd7, 16'hFFFF);
        send_tick(4'hF);
        send_tick(4'h1);    // press on a running device
        repeat (6) send_tick(4'h0);

        // zero service time on the running device, switch to fixed priority
        settle();
        write_reg(REG_SVC_D, 16'h0000);
        write_reg(REG_MODE, 16'hFFFE);
        send_tick(4'h8);
        send_tick(4'hE);
        send_tick(4'h3);
        repeat (5) send_tick(4'h0);

        // mode switches may repeat the all-blocked notice
        settle();
        write_reg(REG_MODE, 16'h0001);
        send_tick(4'h0);
        send_tick(4'h0);
        settle();
        write_reg(REG_MODE, 16'h0000);
        send_tick(4'h0);

        sent = 0;
        while (sent < RAND_TICKS) begin
            settle();
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_MODE, 16'($urandom));
            end
            for (k = 0; k < SVC_REGS; k++) begin
                if ($urandom_range(0, 1) == 1) begin
                    write_reg(REG_SVC_A + CFG_IDX_W'(k), pick_service());
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_IDX_W'($urandom_range(5, 7)), 16'($urandom));
            end
            case ($urandom_range(0, 3))
                0: gap_pct = 0;
                1: gap_pct = 5;
                2: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            hold_req = 1'b1;
            len = $urandom_range(40, 160);
            if (len > RAND_TICKS - sent) begin
                len = RAND_TICKS - sent;
            end
            repeat (len) send_tick(pick_presses());
            sent += len;
        end

        settle();
        write_reg(REG_MODE, 16'($urandom));
        for (k = 0; k < SVC_REGS; k++) begin
            write_reg(REG_SVC_A + CFG_IDX_W'(k), 16'($urandom_range(1, 6)));
        end
        gap_pct = 0;
        repeat (TAIL_TICKS) send_tick(pick_presses());

        settle();
        repeat (4) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
